[hdl/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

  // defaults for the top-level parameters
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed field widths on the ports
  localparam int REQ_W    = 3;
  localparam int POS_W    = 5;
  localparam int VALIN_W  = 32;
  localparam int CAP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOCATE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAN  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // one result, laid out as it sits in out_tdata (status in the low bits)
  typedef struct packed {
    logic                is_full;
    logic                is_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic [FOUND_W-1:0]  found_position;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

[hdl/pal_store.sv]
// ----------------------------------------------------------------------------
// pal_store
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pal_store import pal_pkg::*; #(
  parameter int DEPTH = MAX_ENTRIES_DEF,
  parameter int WIDTH = VALUE_WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/pal_ctrl.sv]
// ----------------------------------------------------------------------------
// pal_ctrl
// Request sequencer: checks, shift and scan passes over the store, count.
// ----------------------------------------------------------------------------
module pal_ctrl import pal_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [CAP_W-1:0]       cfg_wdata,
  // request
  input  logic                   req_valid,
  output logic                   req_ready,
  input  logic [REQ_W-1:0]       req_type,
  input  logic [POS_W-1:0]       req_pos,
  input  logic [VALUE_WIDTH-1:0] req_value,
  // store
  output logic                   mem_we,
  output logic [AW-1:0]          mem_waddr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  output logic                   mem_re,
  output logic [AW-1:0]          mem_raddr,
  input  logic [VALUE_WIDTH-1:0] mem_rdata,
  // result
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]             state_r,  state_nxt;
  logic [CW-1:0]          cnt_r,    cnt_nxt;
  logic [CAP_W-1:0]       cap_r;
  logic [REQ_W-1:0]       op_r,     op_nxt;
  logic [AW-1:0]          pos_r,    pos_nxt;
  logic [VALUE_WIDTH-1:0] val_r,    val_nxt;
  logic [AW-1:0]          idx_r,    idx_nxt;
  logic [AW-1:0]          wa_r,     wa_nxt;
  logic                   more_r,   more_nxt;
  logic                   rdv_r,    rdv_nxt;
  logic [STATUS_W-1:0]    status_r, status_nxt;
  logic [FOUND_W-1:0]     found_r,  found_nxt;

  logic [PW-1:0] pos_w, cnt_w, max_w, cap_w, eff_w;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] last_idx;
  logic          full_now;
  logic          is_ins;

  // effective capacity: saturate to 1..MAX_ENTRIES
  assign pos_w    = PW'(req_pos);
  assign cnt_w    = PW'(cnt_r);
  assign max_w    = PW'(MAX_ENTRIES);
  assign cap_w    = PW'(cap_r);
  assign eff_w    = (cap_r == '0) ? PW'(1) : ((cap_w > max_w) ? max_w : cap_w);
  assign full_now = (cnt_w >= eff_w);
  assign cnt_m1   = cnt_r - 1'b1;
  assign is_ins   = (op_r == REQ_INSERT);
  // insert walks down to its position, delete and locate walk up to the tail
  assign last_idx = is_ins ? pos_r : cnt_m1[AW-1:0];

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    op_nxt     = op_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    wa_nxt     = wa_r;
    more_nxt   = more_r;
    rdv_nxt    = rdv_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    mem_we     = 1'b0;
    mem_waddr  = pos_r;
    mem_wdata  = val_r;
    mem_re     = 1'b0;
    mem_raddr  = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt     = req_type;
          pos_nxt    = pos_w[AW-1:0];
          val_nxt    = req_value;
          status_nxt = ST_OK;
          found_nxt  = '0;
          more_nxt   = 1'b0;
          rdv_nxt    = 1'b0;
          state_nxt  = S_DONE;
          unique case (req_type)
            REQ_INSERT: begin
              if (full_now) begin
                status_nxt = ST_LIMIT;
              end else if (pos_w > cnt_w || pos_w >= max_w) begin
                status_nxt = ST_BADPOS;
              end else if (pos_w == cnt_w) begin
                // append: nothing to move
                mem_we    = 1'b1;
                mem_waddr = pos_w[AW-1:0];
                mem_wdata = req_value;
                cnt_nxt   = cnt_r + 1'b1;
              end else begin
                idx_nxt   = cnt_m1[AW-1:0];
                more_nxt  = 1'b1;
                state_nxt = S_RUN;
              end
            end
            REQ_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_LIMIT;
              end else if (pos_w >= cnt_w) begin
                status_nxt = ST_BADPOS;
              end else if (pos_w == PW'(cnt_m1)) begin
                // tail entry: just drop it
                cnt_nxt = cnt_m1;
              end else begin
                idx_nxt   = pos_w[AW-1:0] + 1'b1;
                more_nxt  = 1'b1;
                state_nxt = S_RUN;
              end
            end
            REQ_LOCATE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                more_nxt  = 1'b1;
                state_nxt = S_RUN;
              end
            end
            REQ_CHANGE: begin
              if (cnt_r == '0) begin
                status_nxt = ST_LIMIT;
              end else if (pos_w >= cnt_w) begin
                status_nxt = ST_BADPOS;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_w[AW-1:0];
                mem_wdata = req_value;
              end
            end
            REQ_CLEAN: begin
              cnt_nxt = '0;
            end
            default: begin
              status_nxt = ST_BADPOS;
            end
          endcase
        end
      end

      S_RUN: begin
        rdv_nxt = 1'b0;
        if (op_r == REQ_LOCATE) begin
          if (rdv_r && mem_rdata == val_r) begin
            found_nxt  = FOUND_W'(wa_r);
            status_nxt = ST_OK;
            more_nxt   = 1'b0;
            state_nxt  = S_DONE;
          end else if (more_r) begin
            mem_re  = 1'b1;
            wa_nxt  = idx_r;
            rdv_nxt = 1'b1;
            if (idx_r == last_idx) begin
              more_nxt = 1'b0;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end else if (!rdv_r) begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_DONE;
          end
        end else begin
          // shift pass: data read last cycle lands one place over
          if (rdv_r) begin
            mem_we    = 1'b1;
            mem_waddr = wa_r;
            mem_wdata = mem_rdata;
          end
          if (more_r) begin
            mem_re  = 1'b1;
            wa_nxt  = is_ins ? (idx_r + 1'b1) : (idx_r - 1'b1);
            rdv_nxt = 1'b1;
            if (idx_r == last_idx) begin
              more_nxt = 1'b0;
            end else begin
              idx_nxt = is_ins ? (idx_r - 1'b1) : (idx_r + 1'b1);
            end
          end else if (!rdv_r) begin
            if (is_ins) begin
              mem_we    = 1'b1;
              mem_waddr = pos_r;
              mem_wdata = val_r;
              cnt_nxt   = cnt_r + 1'b1;
            end else begin
              cnt_nxt = cnt_m1;
            end
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cap_r   <= CAP_RESET;
      more_r  <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      more_r  <= more_nxt;
      rdv_r   <= rdv_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    wa_r     <= wa_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign res.status         = status_r;
  assign res.found_position = found_r;
  assign res.entry_count    = COUNT_W'(cnt_r);
  assign res.is_empty       = (cnt_r == '0);
  assign res.is_full        = full_now;

endmodule

[hdl/positional_array_list.sv]
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed values held in a single-port-pair store.
// ----------------------------------------------------------------------------
//
//  channel | direction | transaction content
//  --------+-----------+---------------------------------------------------
//  in_     | slave     | tuser: req_type; tdata: position, value
//  out_    | master    | tdata: status, found_position, entry_count, flags
//  cfg_    | write     | capacity (5 bits), taken whenever cfg_we is high
//
//  Work per request, n = entry count before the request:
//    failed checks, change, clean, append, tail delete: no pass.
//    insert at p (p < n): shifts p..n-1 up one; delete at p: p+1..n-1 down one.
//    locate: scans up from index 0 and stops at a match or past the tail.
//  With the store's one read and one write port, a pass moves or compares
//  one entry per cycle; read data is registered, so a pass opens with a read.
//  Reset (rst_n low, synchronous) empties the list and sets capacity to 16;
//  stored words are not cleared. One request is in flight at a time; a
//  finished result sits in the output register, so a stalled out_ side holds
//  only the next result, not the next acceptance.
// ----------------------------------------------------------------------------
module positional_array_list import pal_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,   // capacity
  // requests
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,    // [4:0] position, [36:5] value, [39:37] zero
  input  logic [2:0]       in_tuser,    // [2:0] req_type
  // results
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata    // [1:0] status, [5:2] found_position,
                                        // [10:6] entry_count, [11] is_empty,
                                        // [12] is_full, [15:13] zero
);

  localparam int AW = $clog2(MAX_ENTRIES);

  // unpacked request fields
  logic [POS_W-1:0]         in_position;
  logic signed [VALIN_W-1:0] in_value;
  logic [VALUE_WIDTH-1:0]   store_value;

  // store port
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  // sequencer to output register
  logic res_valid;
  logic res_ready;
  res_t res;

  // output register
  logic out_valid_r;
  res_t out_res_r;

  assign in_position = in_tdata[POS_W-1:0];
  assign in_value    = signed'(in_tdata[POS_W +: VALIN_W]);
  // stored as the low bits of the value; wider stores zero-fill
  assign store_value = VALUE_WIDTH'($unsigned(in_value));

  pal_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_type  (in_tuser),
    .req_pos   (in_position),
    .req_value (store_value),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  pal_store #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register: free when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

[hdl/pal_chk.sv]
// ----------------------------------------------------------------------------
// pal_chk
// Port-level checks for positional_array_list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_chk import pal_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             cfg_we,
  input logic [CAP_W-1:0] cfg_wdata,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic [39:0]      in_tdata,
  input logic [2:0]       in_tuser,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [15:0]      out_tdata
);

  // one request at a time: no back-to-back acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one still in progress");

  // empty flag follows the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11] == (out_tdata[10:6] == 5'd0)))
    else $error("is_empty disagrees with entry_count");

  // a failed request reports position zero
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_OK |-> out_tdata[5:2] == 4'd0)
    else $error("found_position set on a failed request");

  // capacity is at least one, so a full list is never empty
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[12] && out_tdata[11]))
    else $error("list reported both full and empty");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

endmodule

bind positional_array_list pal_chk u_pal_chk (.*);
